@@ rtl/segment_ray_intersection_defines.svh @@
// Assertion macros for the segment and ray intersection block
`ifndef SEGMENT_RAY_INTERSECTION_DEFINES_SVH
`define SEGMENT_RAY_INTERSECTION_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SRI_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sri check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SRI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sri check failed");

`endif

@@ rtl/sri_pkg.sv @@
package sri_pkg;

  localparam int LIMIT_WIDTH = 49;

  typedef enum logic [1:0] {
    OUTC_MISS      = 2'd0,
    OUTC_HIT       = 2'd1,
    OUTC_COLLINEAR = 2'd2,
    OUTC_PARALLEL  = 2'd3
  } outcome_e;

  typedef enum logic {
    REG_NEAR_ZERO = 1'b0,
    REG_RAY_MODE  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/sri_front.sv @@
module sri_front #(
  parameter int W = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [W-1:0]               a_start_x_i,
  input  logic signed [W-1:0]               a_start_y_i,
  input  logic signed [W-1:0]               a_end_x_i,
  input  logic signed [W-1:0]               a_end_y_i,
  input  logic signed [W-1:0]               b_start_x_i,
  input  logic signed [W-1:0]               b_start_y_i,
  input  logic signed [W-1:0]               b_end_x_i,
  input  logic signed [W-1:0]               b_end_y_i,
  input  logic [sri_pkg::LIMIT_WIDTH-1:0]   near_zero_limit_i,
  input  logic                              ray_mode_i,
  input  sri_pkg::q_stat_t                  q_stat_i,
  output logic                              push_o,
  output logic [2+2*(2*W+2)+2*(W+1)+2*W-1:0] entry_o
);
  import sri_pkg::*;

  localparam int DW = W + 1;
  localparam int PW = 2 * W + 2;
  localparam int SW = 2 * W + 3;
  localparam int MW = 2 * W + 2;
  localparam int EW = 2 + 2 * MW + 2 * DW + 2 * W;
  localparam int CW = (MW > LIMIT_WIDTH) ? MW : LIMIT_WIDTH;

  logic en, accept;
  logic v1_q, v2_q, v3_q, v4_q;

  logic signed [DW-1:0] s1x_q, s1y_q, s2x_q, s2y_q, dx_q, dy_q, e1x_q, e1y_q;
  logic signed [W-1:0]  p0x_q, p0y_q;

  logic signed [PW-1:0] mden0_q, mden1_q, msn0_q, msn1_q, mtn0_q, mtn1_q, mc0_q, mc1_q;
  logic signed [DW-1:0] s1x2_q, s1y2_q;
  logic signed [W-1:0]  p0x2_q, p0y2_q;

  logic signed [SW-1:0] den_q, sn_q, tn_q, c1_q;
  logic signed [DW-1:0] s1x3_q, s1y3_q;
  logic signed [W-1:0]  p0x3_q, p0y3_q;

  logic signed [SW-1:0] denp, snp, tnp;
  logic [MW-1:0]        den_mag;
  logic                 near, coll, hit;
  outcome_e             outc;
  logic [EW-1:0]        entry_d, entry_q;

  assign en         = !v4_q || !q_stat_i.full;
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;
  assign push_o     = v4_q && !q_stat_i.full;
  assign entry_o    = entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1x_q <= DW'(a_end_x_i) - DW'(a_start_x_i);
      s1y_q <= DW'(a_end_y_i) - DW'(a_start_y_i);
      s2x_q <= DW'(b_end_x_i) - DW'(b_start_x_i);
      s2y_q <= DW'(b_end_y_i) - DW'(b_start_y_i);
      dx_q  <= DW'(a_start_x_i) - DW'(b_start_x_i);
      dy_q  <= DW'(a_start_y_i) - DW'(b_start_y_i);
      e1x_q <= DW'(b_end_x_i) - DW'(a_start_x_i);
      e1y_q <= DW'(b_end_y_i) - DW'(a_start_y_i);
      p0x_q <= a_start_x_i;
      p0y_q <= a_start_y_i;

      mden0_q <= s1x_q * s2y_q;
      mden1_q <= s2x_q * s1y_q;
      msn0_q  <= s1x_q * dy_q;
      msn1_q  <= s1y_q * dx_q;
      mtn0_q  <= s2x_q * dy_q;
      mtn1_q  <= s2y_q * dx_q;
      mc0_q   <= s1x_q * e1y_q;
      mc1_q   <= s1y_q * e1x_q;
      s1x2_q  <= s1x_q;
      s1y2_q  <= s1y_q;
      p0x2_q  <= p0x_q;
      p0y2_q  <= p0y_q;

      den_q  <= SW'(mden0_q) - SW'(mden1_q);
      sn_q   <= SW'(msn0_q) - SW'(msn1_q);
      tn_q   <= SW'(mtn0_q) - SW'(mtn1_q);
      c1_q   <= SW'(mc0_q) - SW'(mc1_q);
      s1x3_q <= s1x2_q;
      s1y3_q <= s1y2_q;
      p0x3_q <= p0x2_q;
      p0y3_q <= p0y2_q;

      entry_q <= entry_d;
    end
  end

  // classify: parallel, collinear, hit or miss
  always_comb begin
    denp    = den_q[SW-1] ? -den_q : den_q;
    snp     = den_q[SW-1] ? -sn_q : sn_q;
    tnp     = den_q[SW-1] ? -tn_q : tn_q;
    den_mag = denp[MW-1:0];
    near    = CW'(den_mag) <= CW'(near_zero_limit_i);
    coll    = (sn_q == '0) && (c1_q == '0);
    hit     = !snp[SW-1] && (snp <= denp) && !tnp[SW-1] && (ray_mode_i || (tnp <= denp));
    if (near) begin
      outc = coll ? OUTC_COLLINEAR : OUTC_PARALLEL;
    end else begin
      outc = hit ? OUTC_HIT : OUTC_MISS;
    end
    entry_d = {outc, tnp[MW-1:0], den_mag, s1x3_q, s1y3_q, p0x3_q, p0y3_q};
  end

endmodule

@@ rtl/sri_queue.sv @@
module sri_queue #(
  parameter int EW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [EW-1:0]    entry_i,
  input  logic             pop_i,
  output logic [EW-1:0]    entry_o,
  output sri_pkg::q_stat_t stat_o
);
  import sri_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  logic [EW-1:0] slot_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  assign entry_o      = slot_q[rd_q];
  assign stat_o.full  = cnt_q == (AW + 1)'(DEPTH);
  assign stat_o.empty = cnt_q == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

endmodule

@@ rtl/sri_div.sv @@
module sri_div #(
  parameter int W = 24
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [3*W+2:0]     num_i,
  input  logic [2*W+1:0]     den_i,
  output logic [W:0]         quot_o,
  output logic               rem_nz_o,
  output logic               ovf_o
);
  localparam int QB = W + 1;
  localparam int MW = 2 * W + 2;
  localparam int NW = 3 * W + 3;

  logic [MW-1:0] r_q   [QB+1];
  logic [QB-1:0] lb_q  [QB+1];
  logic [QB-1:0] qt_q  [QB+1];
  logic [MW-1:0] d_q   [QB+1];
  logic          ovf_q [QB+1];

  logic [MW:0]   trial [1:QB];
  logic [MW:0]   rn    [1:QB];
  logic          ge    [1:QB];

  always_comb begin
    for (int k = 1; k <= QB; k++) begin
      trial[k] = {r_q[k-1], lb_q[k-1][QB-1]};
      ge[k]    = trial[k] >= {1'b0, d_q[k-1]};
      rn[k]    = ge[k] ? (trial[k] - {1'b0, d_q[k-1]}) : trial[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= num_i[NW-1:QB];
      lb_q[0]  <= num_i[QB-1:0];
      qt_q[0]  <= '0;
      d_q[0]   <= den_i;
      ovf_q[0] <= num_i[NW-1:QB] >= den_i;
      for (int k = 1; k <= QB; k++) begin
        r_q[k]   <= rn[k][MW-1:0];
        lb_q[k]  <= lb_q[k-1] << 1;
        qt_q[k]  <= {qt_q[k-1][QB-2:0], ge[k]};
        d_q[k]   <= d_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quot_o   = qt_q[QB];
  assign rem_nz_o = |r_q[QB];
  assign ovf_o    = ovf_q[QB];

endmodule

@@ rtl/sri_back.sv @@
module sri_back #(
  parameter int W = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [2+2*(2*W+2)+2*(W+1)+2*W-1:0] entry_i,
  input  sri_pkg::q_stat_t                   q_stat_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         outcome_o,
  output logic signed [W-1:0]                cross_x_o,
  output logic signed [W-1:0]                cross_y_o
);
  import sri_pkg::*;

  localparam int DW  = W + 1;
  localparam int PW  = 2 * W + 2;
  localparam int MW  = 2 * W + 2;
  localparam int NW  = 3 * W + 3;
  localparam int QB  = W + 1;
  localparam int EW  = 2 + 2 * MW + 2 * DW + 2 * W;
  localparam int SDW = 4 + 2 * W;
  localparam int DL  = QB + 1;
  localparam int OFS_S1Y = 2 * W;
  localparam int OFS_S1X = 2 * W + DW;
  localparam int OFS_DEN = 2 * W + 2 * DW;
  localparam int OFS_TN  = OFS_DEN + MW;

  logic en;
  logic v0_q, v1_q, v2_q, vout_q;
  logic vd_q [DL];

  logic [EW-1:0]        b0_q;
  logic [1:0]           outc0;
  logic [MW-1:0]        tn0, den0;
  logic signed [DW-1:0] s1x0, s1y0;
  logic [DW-1:0]        magx0, magy0;
  logic [SDW-1:0]       side0;

  logic [PW-1:0]  plx_q, phx_q, ply_q, phy_q;
  logic [MW-1:0]  den1_q, den2_q;
  logic [SDW-1:0] side1_q, side2_q;
  logic [SDW-1:0] sd_q [DL];
  logic [NW-1:0]  nx_q, ny_q;

  logic [QB-1:0] qx, qy;
  logic          rzx, rzy, ovx, ovy;
  logic [SDW-1:0] sfin;
  logic [1:0]    outc_f;

  logic [1:0]          outc_q;
  logic signed [W-1:0] cx_q, cy_q;

  function automatic logic [W-1:0] fin_coord(logic [QB-1:0] q, logic rnz, logic ovf,
                                             logic neg, logic [W-1:0] p0);
    logic signed [W+3:0] qs, v;
    logic                fits;
    qs = $signed({3'b000, q});
    if (neg) begin
      qs = -(qs + $signed((W + 4)'(rnz)));
    end
    v = $signed({{4{p0[W-1]}}, p0}) + qs;
    if (v[W+3] && rnz) begin
      v = v + (W + 4)'(1);
    end
    fits = (v[W+3:W-1] == '0) || (v[W+3:W-1] == '1);
    if (ovf) begin
      fin_coord = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else if (!fits) begin
      fin_coord = v[W+3] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      fin_coord = v[W-1:0];
    end
  endfunction

  assign en          = !vout_q || !out_stall_i;
  assign pop_o       = en && !q_stat_i.empty;
  assign out_valid_o = vout_q;
  assign outcome_o   = outc_q;
  assign cross_x_o   = cx_q;
  assign cross_y_o   = cy_q;

  always_comb begin
    outc0 = b0_q[EW-1 -: 2];
    tn0   = b0_q[OFS_TN +: MW];
    den0  = b0_q[OFS_DEN +: MW];
    s1x0  = b0_q[OFS_S1X +: DW];
    s1y0  = b0_q[OFS_S1Y +: DW];
    magx0 = s1x0[DW-1] ? DW'(-s1x0) : DW'(s1x0);
    magy0 = s1y0[DW-1] ? DW'(-s1y0) : DW'(s1y0);
    side0 = {outc0, s1x0[DW-1], s1y0[DW-1], b0_q[2*W-1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      vout_q <= 1'b0;
      for (int k = 0; k < DL; k++) begin
        vd_q[k] <= 1'b0;
      end
    end else if (en) begin
      v0_q    <= pop_o;
      v1_q    <= v0_q;
      v2_q    <= v1_q;
      vd_q[0] <= v2_q;
      for (int k = 1; k < DL; k++) begin
        vd_q[k] <= vd_q[k-1];
      end
      vout_q  <= vd_q[DL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b0_q    <= entry_i;
      plx_q   <= tn0[DW-1:0] * magx0;
      phx_q   <= tn0[MW-1:DW] * magx0;
      ply_q   <= tn0[DW-1:0] * magy0;
      phy_q   <= tn0[MW-1:DW] * magy0;
      den1_q  <= den0;
      side1_q <= side0;
      nx_q    <= NW'(plx_q) + (NW'(phx_q) << DW);
      ny_q    <= NW'(ply_q) + (NW'(phy_q) << DW);
      den2_q  <= den1_q;
      side2_q <= side1_q;
      sd_q[0] <= side2_q;
      for (int k = 1; k < DL; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
      outc_q <= outc_f;
      if (outc_f == OUTC_HIT) begin
        cx_q <= fin_coord(qx, rzx, ovx, sfin[2*W+1], sfin[2*W-1:W]);
        cy_q <= fin_coord(qy, rzy, ovy, sfin[2*W], sfin[W-1:0]);
      end else begin
        cx_q <= '0;
        cy_q <= '0;
      end
    end
  end

  assign sfin   = sd_q[DL-1];
  assign outc_f = sfin[SDW-1 -: 2];

  sri_div #(.W(W)) u_div_x (
    .clk_i    (clk_i),
    .en_i     (en),
    .num_i    (nx_q),
    .den_i    (den2_q),
    .quot_o   (qx),
    .rem_nz_o (rzx),
    .ovf_o    (ovx)
  );

  sri_div #(.W(W)) u_div_y (
    .clk_i    (clk_i),
    .en_i     (en),
    .num_i    (ny_q),
    .den_i    (den2_q),
    .quot_o   (qy),
    .rem_nz_o (rzy),
    .ovf_o    (ovy)
  );

endmodule

@@ rtl/segment_ray_intersection.sv @@
// Throughput: one item per cycle while out_stall_i is low; a classifying front end feeds a
// four-entry queue, drained by the multiply and restoring-divide pipeline,
// which takes one quotient bit per stage.
// Reset: asynchronous, active low; clears all valid state, near_zero_limit and ray_mode.
module segment_ray_intersection #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]    a_start_x_i,
  input  logic signed [COORD_WIDTH-1:0]    a_start_y_i,
  input  logic signed [COORD_WIDTH-1:0]    a_end_x_i,
  input  logic signed [COORD_WIDTH-1:0]    a_end_y_i,
  input  logic signed [COORD_WIDTH-1:0]    b_start_x_i,
  input  logic signed [COORD_WIDTH-1:0]    b_start_y_i,
  input  logic signed [COORD_WIDTH-1:0]    b_end_x_i,
  input  logic signed [COORD_WIDTH-1:0]    b_end_y_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       outcome_o,
  output logic signed [COORD_WIDTH-1:0]    cross_x_o,
  output logic signed [COORD_WIDTH-1:0]    cross_y_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_index_i,
  input  logic [sri_pkg::LIMIT_WIDTH-1:0]  cfg_data_i
);
  import sri_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int EW = 2 + 2 * (2 * W + 2) + 2 * (W + 1) + 2 * W;

  logic [LIMIT_WIDTH-1:0] limit_q;
  logic                   ray_q;
  q_stat_t                q_stat;
  logic                   push, pop;
  logic [EW-1:0]          entry_in, entry_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
      ray_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_NEAR_ZERO: limit_q <= cfg_data_i;
        REG_RAY_MODE:  ray_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  sri_front #(.W(W)) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .a_start_x_i       (a_start_x_i),
    .a_start_y_i       (a_start_y_i),
    .a_end_x_i         (a_end_x_i),
    .a_end_y_i         (a_end_y_i),
    .b_start_x_i       (b_start_x_i),
    .b_start_y_i       (b_start_y_i),
    .b_end_x_i         (b_end_x_i),
    .b_end_y_i         (b_end_y_i),
    .near_zero_limit_i (limit_q),
    .ray_mode_i        (ray_q),
    .q_stat_i          (q_stat),
    .push_o            (push),
    .entry_o           (entry_in)
  );

  sri_queue #(.EW(EW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry_in),
    .pop_i   (pop),
    .entry_o (entry_out),
    .stat_o  (q_stat)
  );

  sri_back #(.W(W)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (entry_out),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .outcome_o   (outcome_o),
    .cross_x_o   (cross_x_o),
    .cross_y_o   (cross_y_o)
  );

endmodule

@@ rtl/sri_checker.sv @@
`include "segment_ray_intersection_defines.svh"

module sri_checker #(
  parameter int COORD_WIDTH = 24
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [1:0]                    outcome_o,
  input logic signed [COORD_WIDTH-1:0] cross_x_o,
  input logic signed [COORD_WIDTH-1:0] cross_y_o
);
  import sri_pkg::*;

  `SRI_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `SRI_ASSERT_SAME(a_miss_zero, out_valid_o && outcome_o != OUTC_HIT, !(|{cross_x_o, cross_y_o}))
  `SRI_ASSERT_SAME(a_reset_quiet, $past(!rst_ni), !out_valid_o)

endmodule

bind segment_ray_intersection sri_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sri_checker (.*);

@@ sim/tb_segment_ray_intersection.sv @@
`timescale 1ns / 100ps

module tb_segment_ray_intersection;
  import sri_pkg::*;

  localparam int CW = 24;
  localparam int LATENCY = CW + 10;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    outcome_e outcome;
    coord_t   x;
    coord_t   y;
  } isect_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  coord_t                 a_start_x_i, a_start_y_i, a_end_x_i, a_end_y_i;
  coord_t                 b_start_x_i, b_start_y_i, b_end_x_i, b_end_y_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [1:0]             outcome_o;
  coord_t                 cross_x_o, cross_y_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic                   cfg_index_i;
  logic [LIMIT_WIDTH-1:0] cfg_data_i;

  logic [LIMIT_WIDTH-1:0] near_limit;
  logic                   ray_on;
  isect_t                 pending_isects[$];
  int                     fail_count;
  longint                 cycle_count;
  int                     send_idle_pct;
  int                     stall_pct;
  int                     hold_left;

  segment_ray_intersection #(.COORD_WIDTH(CW)) uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic coord_t crossing_coord(longint p0, longint d, longint tn, longint den);
    logic [127:0] prod;
    logic [127:0] quot;
    logic [127:0] rem;
    logic [63:0]  mt;
    logic [63:0]  md;
    longint       qs;
    longint       v;
    bit           neg;
    neg  = (d < 0) != (tn < 0);
    mt   = (tn < 0) ? -tn : tn;
    md   = (d < 0) ? -d : d;
    prod = {64'b0, mt} * {64'b0, md};
    quot = prod / {64'b0, den};
    rem  = prod % {64'b0, den};
    if (quot > (128'd1 << 40)) quot = 128'd1 << 40;
    qs = longint'(quot[63:0]);
    if (neg) qs = -qs - ((rem != 0) ? 1 : 0);
    v = p0 + qs;
    if (v < 0 && rem != 0) v += 1;
    if (v > 64'sd8388607) v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    return coord_t'(v[CW-1:0]);
  endfunction

  function automatic isect_t predict_isect(coord_t c[8]);
    isect_t      res;
    longint      p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;
    longint      s1x, s1y, s2x, s2y, dx, dy, den, sn, tn, c0, c1;
    logic [63:0] mag_den;
    p0x = c[0]; p0y = c[1]; p1x = c[2]; p1y = c[3];
    p2x = c[4]; p2y = c[5]; p3x = c[6]; p3y = c[7];
    s1x = p1x - p0x; s1y = p1y - p0y;
    s2x = p3x - p2x; s2y = p3y - p2y;
    dx = p0x - p2x; dy = p0y - p2y;
    den = s1x * s2y - s2x * s1y;
    res.outcome = OUTC_MISS;
    res.x = '0;
    res.y = '0;
    mag_den = (den < 0) ? -den : den;
    if (mag_den <= {15'b0, near_limit}) begin
      c0 = s1x * (p2y - p0y) - s1y * (p2x - p0x);
      c1 = s1x * (p3y - p0y) - s1y * (p3x - p0x);
      res.outcome = (c0 == 0 && c1 == 0) ? OUTC_COLLINEAR : OUTC_PARALLEL;
      return res;
    end
    sn = s1x * dy - s1y * dx;
    tn = s2x * dy - s2y * dx;
    if (den < 0) begin
      den = -den; sn = -sn; tn = -tn;
    end
    if (sn >= 0 && sn <= den && tn >= 0 && (ray_on || tn <= den)) begin
      res.outcome = OUTC_HIT;
      res.x = crossing_coord(p0x, s1x, tn, den);
      res.y = crossing_coord(p0y, s1y, tn, den);
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    isect_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_isects.size() == 0) begin
        $error("result with nothing pending: outcome %0d", outcome_o);
        fail_count++;
      end else begin
        want = pending_isects.pop_front();
        if (outcome_o !== want.outcome) begin
          $error("outcome expected %0d actual %0d", want.outcome, outcome_o);
          fail_count++;
        end
        if (cross_x_o !== want.x) begin
          $error("cross_x expected %0d actual %0d", want.x, cross_x_o);
          fail_count++;
        end
        if (cross_y_o !== want.y) begin
          $error("cross_y expected %0d actual %0d", want.y, cross_y_o);
          fail_count++;
        end
      end
    end
  end

  task automatic send_item(coord_t c[8]);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    {a_start_x_i, a_start_y_i, a_end_x_i, a_end_y_i} = {c[0], c[1], c[2], c[3]};
    {b_start_x_i, b_start_y_i, b_end_x_i, b_end_y_i} = {c[4], c[5], c[6], c[7]};
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_isects.insert(pending_isects.size(), predict_isect(c));
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (pending_isects.size() == 0);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [LIMIT_WIDTH-1:0] val);
    drain();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_NEAR_ZERO) near_limit = val;
    else ray_on = val[0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic coord_t rand_coord(int span);
    if (span == 0) return coord_t'($urandom());
    return coord_t'($urandom_range(2 * span) - span);
  endfunction

  task automatic send_shaped(int span);
    coord_t c[8];
    int     k;
    int     m;
    for (int i = 0; i < 8; i++) c[i] = rand_coord(span);
    k = $urandom_range(99);
    m = $urandom_range(6) - 3;
    if (k < 15) begin
      c[4] = c[0] + m * (c[2] - c[0]);
      c[5] = c[1] + m * (c[3] - c[1]);
      m = $urandom_range(6) - 3;
      c[6] = c[0] + m * (c[2] - c[0]);
      c[7] = c[1] + m * (c[3] - c[1]);
      if (k < 8) begin
        c[4] = c[4] + 1;
        c[6] = c[6] + 1;
      end
    end else if (k < 20) begin
      c[2] = c[0];
      c[3] = c[1];
    end
    send_item(c);
  endtask

  task automatic test_directed();
    coord_t mx;
    coord_t mn;
    mx = 24'sh7FFFFF;
    mn = -24'sh800000;
    send_item('{0, 0, 100, 100, 0, 100, 100, 0});
    send_item('{0, 0, 100, 0, 100, -50, 100, 50});
    send_item('{0, 0, 100, 0, 0, -50, 0, 50});
    send_item('{0, 0, 100, 0, 200, -50, 200, 50});
    send_item('{0, 0, 100, 0, 50, 10, 50, 60});
    send_item('{0, 0, 100, 0, 20, 0, 70, 0});
    send_item('{0, 0, 100, 0, 20, 5, 70, 5});
    send_item('{5, 5, 5, 5, 1, 2, 3, 4});
    send_item('{mn, mn, mx, mx, mn, mx, mx, mn});
    send_item('{mx, mx, mn, mn, mx, mn, mn, mx});
    send_item('{mn, mx, mx, mn, mn, mn, mx, mx});
    send_item('{mn, mn, mn + 1, mn + 1, mx, mn, mx - 1, mn + 1});
    send_item('{0, 0, 3, 7, 1, 0, 0, 9});
    send_item('{-7, 3, 11, -5, -9, -9, 13, 8});
    send_item('{mx, 0, mx, 0, mn, mn, mx, mx});
    send_item('{-1, -1, 1, 1, -1, 1, 1, -1});
    write_reg(REG_RAY_MODE, 1);
    send_item('{0, 0, 10, 0, 200, -50, 200, 50});
    send_item('{0, 0, 10, 0, -200, -50, -200, 50});
    send_item('{mn, mn, mn + 1, mn + 1, mx, mn, mn, mx});
    send_item('{0, 0, 1, 3, mx, mn, mx, mx});
    write_reg(REG_NEAR_ZERO, 20000);
    send_item('{0, 0, 100, 0, 50, 10, 50, 60});
    send_item('{0, 0, 100, 1, 0, 5, 100, 5});
    write_reg(REG_NEAR_ZERO, {LIMIT_WIDTH{1'b1}});
    send_item('{mn, mn, mx, mx, mn, mx, mx, mn});
    send_item('{0, 0, 100, 0, 20, 0, 70, 0});
    drain();
  endtask

  task automatic test_random(int count, int idle, int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: send_shaped(0);
        1: send_shaped(300);
        2: send_shaped(40000);
        default: send_shaped(2000000);
      endcase
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    @(negedge clk_i);
    hold_left = 400;
    for (int i = 0; i < 60; i++) send_shaped(300);
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_NEAR_ZERO;
    cfg_data_i = '0;
    {a_start_x_i, a_start_y_i, a_end_x_i, a_end_y_i} = '0;
    {b_start_x_i, b_start_y_i, b_end_x_i, b_end_y_i} = '0;
    near_limit = '0;
    ray_on = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    write_reg(REG_NEAR_ZERO, 0);
    write_reg(REG_RAY_MODE, 0);
    test_random(250, 0, 0);
    test_random(250, 67, 0);
    write_reg(REG_RAY_MODE, 1);
    test_random(250, 0, 67);
    test_random(250, 33, 33);
    write_reg(REG_NEAR_ZERO, 5000);
    test_random(150, 33, 33);
    write_reg(REG_RAY_MODE, 0);
    write_reg(REG_NEAR_ZERO, {LIMIT_WIDTH{1'b1}});
    test_random(100, 0, 0);
    write_reg(REG_NEAR_ZERO, 1 << 30);
    test_random(100, 67, 67);
    test_backpressure();

    repeat (LATENCY + 20) @(posedge clk_i);
    if (fail_count == 0 && pending_isects.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
